// ===== rtl/itoa_pkg.sv =====
package itoa_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int MAX_CHARS       = 32;
   // digit counts and binary lengths up to 64
   localparam int CNT_W           = 7;
   localparam int DABBLE_STEPS    = 8;

   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_MINUS    = 8'h2D;
   localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

   typedef enum logic [2:0] {
      KIND_UDEC = 3'd0,
      KIND_SDEC = 3'd1,
      KIND_HEX  = 3'd2,
      KIND_OCT  = 3'd3,
      KIND_BIN  = 3'd4
   } kind_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic [5:0]  bit_count;
   } req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_type;

   typedef struct packed {
      kind_type         kind;
      logic             neg;
      logic [CNT_W-1:0] nbin;
   } ctl_type;

   // decimal digits of 2**w - 1
   function automatic int dec_digits(input int w);
      return ((w * 1233) >> 12) + 1;
   endfunction

endpackage

// ===== rtl/itoa_prep.sv =====
module itoa_prep #(
   parameter int VW = itoa_pkg::VALUE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  itoa_pkg::req_type              in_req,
   output logic                           out_valid,
   input  logic                           out_ready,
   output itoa_pkg::ctl_type              out_ctl,
   output logic [VW-1:0]                  out_val,
   output logic [itoa_pkg::dec_digits(VW)*4-1:0] out_bcd
);
   import itoa_pkg::*;

   localparam int BCD_W = dec_digits(VW) * 4;

   logic              valid_ff;
   ctl_type           ctl_ff, ctl_in;
   logic [VW-1:0]     val_ff, val_in;
   logic [VW-1:0]     v;
   logic [CNT_W-1:0]  n;

   always_comb begin
      v = VW'(in_req.value);
      n = CNT_W'(in_req.bit_count);
      if (n > CNT_W'(VW))        n = CNT_W'(VW);
      if (n > CNT_W'(MAX_CHARS)) n = CNT_W'(MAX_CHARS);
      ctl_in.nbin = n;
      ctl_in.neg  = 1'b0;
      val_in      = v;
      case (in_req.kind)
         KIND_SDEC: begin
            ctl_in.kind = KIND_SDEC;
            ctl_in.neg  = v[VW-1];
            if (v[VW-1]) val_in = ~v + 1'b1;
         end
         KIND_HEX: ctl_in.kind = KIND_HEX;
         KIND_OCT: ctl_in.kind = KIND_OCT;
         KIND_BIN: begin
            ctl_in.kind = KIND_BIN;
            // top-align the printed bits
            val_in = v << (CNT_W'(VW) - n);
         end
         default: ctl_in.kind = KIND_UDEC;
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         ctl_ff <= ctl_in;
         val_ff <= val_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_val   = val_ff;
   assign out_bcd   = {BCD_W{1'b0}};

endmodule

// ===== rtl/itoa_dabble.sv =====
module itoa_dabble #(
   parameter int VW    = itoa_pkg::VALUE_WIDTH_DEF,
   parameter int STAGE = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  itoa_pkg::ctl_type              in_ctl,
   input  logic [VW-1:0]                  in_val,
   input  logic [itoa_pkg::dec_digits(VW)*4-1:0] in_bcd,
   output logic                           out_valid,
   input  logic                           out_ready,
   output itoa_pkg::ctl_type              out_ctl,
   output logic [VW-1:0]                  out_val,
   output logic [itoa_pkg::dec_digits(VW)*4-1:0] out_bcd
);
   import itoa_pkg::*;

   localparam int DEC_D = dec_digits(VW);
   localparam int BCD_W = DEC_D * 4;

   logic              valid_ff;
   ctl_type           ctl_ff;
   logic [VW-1:0]     val_ff, val_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;

   // shift-and-add-3, a slice of the input bits per stage
   always_comb begin
      val_in = in_val;
      bcd_in = in_bcd;
      if (in_ctl.kind == KIND_UDEC || in_ctl.kind == KIND_SDEC) begin
         for (int k = 0; k < DABBLE_STEPS; k++) begin
            if (STAGE * DABBLE_STEPS + k < VW) begin
               for (int d = 0; d < DEC_D; d++) begin
                  if (bcd_in[4*d +: 4] >= 4'd5) bcd_in[4*d +: 4] = bcd_in[4*d +: 4] + 4'd3;
               end
               bcd_in = {bcd_in[BCD_W-2:0], val_in[VW-1]};
               val_in = {val_in[VW-2:0], 1'b0};
            end
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         ctl_ff <= in_ctl;
         val_ff <= val_in;
         bcd_ff <= bcd_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_val   = val_ff;
   assign out_bcd   = bcd_ff;

endmodule

// ===== rtl/itoa_serial.sv =====
module itoa_serial #(
   parameter int VW = itoa_pkg::VALUE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  itoa_pkg::ctl_type              in_ctl,
   input  logic [VW-1:0]                  in_val,
   input  logic [itoa_pkg::dec_digits(VW)*4-1:0] in_bcd,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output itoa_pkg::rsp_type              rsp_data
);
   import itoa_pkg::*;

   localparam int DEC_D = dec_digits(VW);
   localparam int HEX_D = (VW + 3) / 4;
   localparam int OCT_D = (VW + 2) / 3;

   logic [VW-1:0][3:0]  dig_ff, dig_load;
   logic [CNT_W-1:0]    cnt_ff, cnt_load;
   logic                busy_ff, neg_ff, lead_ff, supp_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;
   logic [HEX_D*4-1:0]  valx;
   logic [OCT_D*3-1:0]  valo;
   logic [3:0]          top;
   logic                out_free, step, emit;

   // top-aligned digit layout per kind
   always_comb begin
      valx     = (HEX_D*4)'(in_val);
      valo     = (OCT_D*3)'(in_val);
      dig_load = '0;
      case (in_ctl.kind)
         KIND_HEX: begin
            for (int j = 0; j < HEX_D; j++) dig_load[VW-HEX_D+j] = valx[4*j +: 4];
            cnt_load = CNT_W'(HEX_D);
         end
         KIND_OCT: begin
            for (int j = 0; j < OCT_D; j++) dig_load[VW-OCT_D+j] = {1'b0, valo[3*j +: 3]};
            cnt_load = CNT_W'(OCT_D);
         end
         KIND_BIN: begin
            for (int j = 0; j < VW; j++) dig_load[j] = {3'b000, in_val[j]};
            cnt_load = in_ctl.nbin;
         end
         default: begin
            for (int j = 0; j < DEC_D; j++) dig_load[VW-DEC_D+j] = in_bcd[4*j +: 4];
            cnt_load = CNT_W'(DEC_D);
         end
      endcase
   end

   assign top      = dig_ff[VW-1];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign step     = busy_ff && out_free;
   // leading zeros are dropped without a word going out
   assign emit     = step && (neg_ff || !(lead_ff && supp_ff && top == 4'd0 &&
                                          cnt_ff > CNT_W'(1)));
   assign in_ready = !busy_ff;

   always_comb begin
      if (neg_ff) begin
         rsp_in.character = CHAR_MINUS;
      end else if (top < 4'd10) begin
         rsp_in.character = CHAR_ZERO + 8'(top);
      end else begin
         rsp_in.character = HEX_ALPHA_OFS + 8'(top);
      end
      rsp_in.last = !neg_ff && cnt_ff == CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!busy_ff) begin
            busy_ff <= in_valid && cnt_load != '0;
         end else if (step && !neg_ff && cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
         if (out_free) rsp_valid_ff <= emit;
      end
      if (!busy_ff && in_valid) begin
         dig_ff  <= dig_load;
         cnt_ff  <= cnt_load;
         neg_ff  <= in_ctl.neg;
         lead_ff <= 1'b1;
         supp_ff <= in_ctl.kind != KIND_BIN;
      end else if (step) begin
         if (neg_ff) begin
            neg_ff <= 1'b0;
         end else begin
            dig_ff <= {dig_ff[VW-2:0], 4'h0};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (emit) lead_ff <= 1'b0;
         end
      end
      if (emit) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/integer_to_ascii_radix_formatter_unit.sv =====
// Prints a number as ASCII text, most significant character first, one word per
// character with last set on the final one: kind 0 unsigned decimal, 1 signed
// decimal ('-' then magnitude), 2 uppercase hex, 3 octal, 4 binary of bit_count
// digits (at most 32) with leading zeros; kinds 5 to 7 print unsigned decimal.
// A number goes through a prep stage and ceil(VALUE_WIDTH/8) binary-to-BCD stages
// (8 shift-add steps each), then a serializer that sends one character per cycle
// unless the output stalls. The serializer sets the rate: it takes a new number
// only when idle, then steps through each digit position of its kind (10 decimal,
// 8 hex, 11 octal at 32 bits, bit_count binary) plus a step for a minus sign;
// leading zeros are skipped a step each. The pipeline ahead of it keeps taking
// numbers while it works, and a finished character waits in an output register.
module integer_to_ascii_radix_formatter_unit #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  itoa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output itoa_pkg::rsp_type rsp_data
);
   import itoa_pkg::*;

   localparam int BCD_W = dec_digits(VALUE_WIDTH) * 4;
   localparam int DD_N  = (VALUE_WIDTH + DABBLE_STEPS - 1) / DABBLE_STEPS;

   logic                   valid [DD_N+1];
   logic                   ready [DD_N+1];
   ctl_type                ctl   [DD_N+1];
   logic [VALUE_WIDTH-1:0] val   [DD_N+1];
   logic [BCD_W-1:0]       bcd   [DD_N+1];

   itoa_prep #(.VW(VALUE_WIDTH)) u_prep (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_req(req_data),
      .out_valid(valid[0]), .out_ready(ready[0]),
      .out_ctl(ctl[0]), .out_val(val[0]), .out_bcd(bcd[0])
   );

   for (genvar s = 0; s < DD_N; s++) begin : g_dabble
      itoa_dabble #(.VW(VALUE_WIDTH), .STAGE(s)) u_dabble (
         .clock(clock), .reset(reset),
         .in_valid(valid[s]), .in_ready(ready[s]),
         .in_ctl(ctl[s]), .in_val(val[s]), .in_bcd(bcd[s]),
         .out_valid(valid[s+1]), .out_ready(ready[s+1]),
         .out_ctl(ctl[s+1]), .out_val(val[s+1]), .out_bcd(bcd[s+1])
      );
   end

   itoa_serial #(.VW(VALUE_WIDTH)) u_serial (
      .clock(clock), .reset(reset),
      .in_valid(valid[DD_N]), .in_ready(ready[DD_N]),
      .in_ctl(ctl[DD_N]), .in_val(val[DD_N]), .in_bcd(bcd[DD_N]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

endmodule

// ===== sim/integer_to_ascii_radix_formatter_unit_checker.sv =====
`timescale 1ns / 100ps

module integer_to_ascii_radix_formatter_unit_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  itoa_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  itoa_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_chars,
   output int                chars_seen
);
   import itoa_pkg::*;

   rsp_type text_queue[$];

   // digits of v in radix, most significant first
   task automatic push_radix(input logic [31:0] v, input int radix);
      logic [7:0] digits[$];
      int rem;
      digits = {};
      if (v == 0) digits.push_front(CHAR_ZERO);
      while (v != 0) begin
         rem = v % radix;
         digits.push_front(8'(rem < 10 ? CHAR_ZERO + rem : HEX_ALPHA_OFS + rem));
         v = v / radix;
      end
      foreach (digits[i]) text_queue.push_back('{character: digits[i], last: 1'b0});
   endtask

   task automatic predict_text(input req_type r);
      int before_len;
      int nb;
      logic [31:0] v;
      before_len = text_queue.size();
      v = r.value;
      case (r.kind)
         KIND_SDEC: begin
            if (v[31]) begin
               text_queue.push_back('{character: CHAR_MINUS, last: 1'b0});
               v = -v;
            end
            push_radix(v, 10);
         end
         KIND_HEX: push_radix(v, 16);
         KIND_OCT: push_radix(v, 8);
         KIND_BIN: begin
            nb = r.bit_count > 32 ? 32 : r.bit_count;
            for (int i = nb - 1; i >= 0; i--)
               text_queue.push_back('{character: CHAR_ZERO + v[i], last: 1'b0});
         end
         default: push_radix(v, 10);
      endcase
      if (text_queue.size() > before_len) text_queue[$].last = 1'b1;
   endtask

   rsp_type exp_word;
   always @(posedge clock) begin
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
         chars_seen <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            chars_seen <= chars_seen + 1;
            if (text_queue.size() == 0) begin
               $error("unexpected word char=%h last=%b", rsp_data.character, rsp_data.last);
               errs++;
            end else begin
               exp_word = text_queue.pop_front();
               if (exp_word.character !== rsp_data.character) begin
                  $error("character expected %h actual %h", exp_word.character,
                         rsp_data.character);
                  errs++;
               end
               if (exp_word.last !== rsp_data.last) begin
                  $error("last expected %b actual %b", exp_word.last, rsp_data.last);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) predict_text(req_data);
         fail_count <= fail_count + errs;
      end
   end

   assign pending_chars = text_queue.size();
endmodule

// ===== sim/integer_to_ascii_radix_formatter_unit_test.sv =====
`timescale 1ns / 100ps

module integer_to_ascii_radix_formatter_unit_test;
   import itoa_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;
   int      fail_count, pending_chars, chars_seen;
   int      numbers_sent = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   integer_to_ascii_radix_formatter_unit dut (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   integer_to_ascii_radix_formatter_unit_checker checker_i (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data), .fail_count(fail_count), .pending_chars(pending_chars),
      .chars_seen(chars_seen)
   );

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
      return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
   endfunction

   logic quiet_phase = 0;
   int   stall_left = 0;

   // sink side stalls, held low for the whole gap
   always @(posedge clock) begin
      int g;
      if (reset) begin
         rsp_ready  <= 0;
         stall_left <= 0;
      end else if (quiet_phase) begin
         rsp_ready <= 1;
      end else if (stall_left != 0) begin
         rsp_ready  <= 0;
         stall_left <= stall_left - 1;
      end else begin
         g = gap_len();
         rsp_ready  <= (g == 0);
         stall_left <= (g == 0) ? 0 : g - 1;
      end
   end

   task automatic send_number(input logic [2:0] k, input logic [31:0] v,
                              input logic [5:0] n);
      int g;
      g = gap_len();
      if (g != 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= '{kind: k, value: v, bit_count: n};
      // ready is stable between edges; look at it before the edge
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      numbers_sent++;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 9);
         1: return $urandom_range(0, 1000);
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [2:0] k;
      logic [5:0] n;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, each kind, unused kinds, binary edge counts
      send_number(KIND_UDEC, 32'd0, 6'd0);
      send_number(KIND_UDEC, 32'hFFFF_FFFF, 6'd0);
      send_number(KIND_SDEC, 32'd0, 6'd0);
      send_number(KIND_SDEC, 32'h8000_0000, 6'd0);
      send_number(KIND_SDEC, 32'hFFFF_FFFF, 6'd0);
      send_number(KIND_SDEC, 32'h7FFF_FFFF, 6'd0);
      send_number(KIND_HEX, 32'd0, 6'd0);
      send_number(KIND_HEX, 32'hFFFF_FFFF, 6'd0);
      send_number(KIND_HEX, 32'h0ABC_DEF9, 6'd0);
      send_number(KIND_OCT, 32'd0, 6'd0);
      send_number(KIND_OCT, 32'hFFFF_FFFF, 6'd0);
      send_number(KIND_BIN, 32'hFFFF_FFFF, 6'd0);
      send_number(KIND_BIN, 32'h5555_5555, 6'd1);
      send_number(KIND_BIN, 32'hAAAA_AAAA, 6'd32);
      send_number(KIND_BIN, 32'h1234_5678, 6'd63);
      send_number(KIND_BIN, 32'h0, 6'd33);
      send_number(3'd5, 32'd12345, 6'd0);
      send_number(3'd6, 32'hFFFF_FFFF, 6'd63);
      send_number(3'd7, 32'd0, 6'd21);
      req_valid <= 0;
      // drain fully before going on
      while (pending_chars != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      for (int i = 0; i < 310; i++) begin
         k = 3'($urandom_range(0, 7));
         n = $urandom_range(0, 3) == 0 ? 6'($urandom_range(0, 63))
                                       : 6'($urandom_range(1, 8));
         if (i == 150) begin
            req_valid <= 0;
            while (pending_chars != 0) @(posedge clock);
            @(posedge clock);
         end
         quiet_phase <= (i >= 200 && i < 230);
         send_number(k, rand_value(), n);
      end
      quiet_phase <= 0;
      req_valid   <= 0;
      while (pending_chars != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("sent %0d numbers over all kinds, checked %0d characters",
               numbers_sent, chars_seen);
      if (fail_count == 0 && pending_chars == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #10000000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
